// ===== src/est_pkg.sv =====
// Shared types and codes for the slewed thruster tick block.
// No dependencies; every other file in src uses this package.
package est_pkg;

	// Item codes
	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_RPM    = 2'd1;
	localparam logic [1:0] FUNC_EFFORT = 2'd2;
	localparam logic [1:0] FUNC_KILL   = 2'd3;

	// Configuration register indexes; the index field has room for unused codes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_COEF   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAD_COEF  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AIR_DECAY  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLIP_GAIN  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPD_FLOOR  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPD_CEIL   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_COEF = 4'd7;

	// Register reset values
	localparam logic signed [23:0] SPD_CEIL_RST = 24'sd2560000;
	localparam logic [22:0]        MAX_STEP_RST = 23'd256;

	// Multiplier operand selects
	typedef logic [3:0] mul_sel_t;
	localparam mul_sel_t MUL_NONE = 4'd0;
	localparam mul_sel_t MUL_EFF  = 4'd1;
	localparam mul_sel_t MUL_SLIP = 4'd2;
	localparam mul_sel_t MUL_LIN  = 4'd3;
	localparam mul_sel_t MUL_SQ   = 4'd4;
	localparam mul_sel_t MUL_AA   = 4'd5;
	localparam mul_sel_t MUL_QUAD = 4'd6;
	localparam mul_sel_t MUL_KVH  = 4'd7;
	localparam mul_sel_t MUL_KVL  = 4'd8;
	localparam mul_sel_t MUL_THR  = 4'd9;
	localparam mul_sel_t MUL_PW1  = 4'd10;
	localparam mul_sel_t MUL_PH   = 4'd11;
	localparam mul_sel_t MUL_PL   = 4'd12;

	// Product writeback selects
	typedef logic [3:0] wb_sel_t;
	localparam wb_sel_t WB_NONE = 4'd0;
	localparam wb_sel_t WB_CMD  = 4'd1;
	localparam wb_sel_t WB_SLEW = 4'd2;
	localparam wb_sel_t WB_MAG  = 4'd3;
	localparam wb_sel_t WB_LIN  = 4'd4;
	localparam wb_sel_t WB_SQ   = 4'd5;
	localparam wb_sel_t WB_AA   = 4'd6;
	localparam wb_sel_t WB_QUAD = 4'd7;
	localparam wb_sel_t WB_KVH  = 4'd8;
	localparam wb_sel_t WB_FACT = 4'd9;
	localparam wb_sel_t WB_THR  = 4'd10;
	localparam wb_sel_t WB_PWR1 = 4'd11;
	localparam wb_sel_t WB_PH   = 4'd12;
	localparam wb_sel_t WB_PWR2 = 4'd13;

	typedef struct packed {
		logic     load;
		mul_sel_t mul_sel;
		wb_sel_t  wb_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic pc_neg;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== src/est_if.sv =====
// Handshake channels of the slewed thruster tick block: input item, result, config write.
// Depends on est_pkg for the config index width.
interface est_tick_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [23:0] command_value;
	logic signed [31:0] axial_airspeed;

	modport source(output valid, func, command_value, axial_airspeed, input ready);
	modport sink(input valid, func, command_value, axial_airspeed, output ready);
endinterface

interface est_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] speed_out;
	logic signed [31:0] thrust_out;
	logic [31:0]        power_out;

	modport source(output valid, speed_out, thrust_out, power_out, input ready);
	modport sink(input valid, speed_out, thrust_out, power_out, output ready);
endinterface

interface est_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [est_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/est_dp.sv =====
// Datapath: config registers, tick state, one shared 33x33 multiplier and writeback logic.
// Depends on est_pkg; driven by est_ctrl through dp_cmd_t.
module est_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  est_pkg::dp_cmd_t              cmd,
	output est_pkg::dp_stat_t             stat,
	input  logic                          cfg_we,
	input  logic [est_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic [1:0]                    func,
	input  logic signed [23:0]            command_value,
	input  logic signed [31:0]            axial_airspeed,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic signed [23:0]            speed_out,
	output logic signed [31:0]            thrust_out,
	output logic [31:0]                   power_out
);

	localparam logic signed [23:0] SPD_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SPD_MIN = 24'sh800000;
	localparam logic signed [31:0] W32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] W32_MIN = 32'sh80000000;
	localparam logic [16:0]        UNITY   = 17'h10000;

	// config
	logic signed [31:0] lin_q, quad_q, ks_q, pc_q;
	logic [31:0]        kv_q, pcmag_q;
	logic signed [23:0] floor_q, ceil_q;
	logic [22:0]        step_q;

	// tick state
	logic signed [23:0] shaft_q, cmd_q;
	logic signed [31:0] last_q;

	// item and intermediates
	logic [1:0]         func_q;
	logic signed [23:0] cv_q;
	logic signed [31:0] axial_q, a_q, q_q;
	logic [23:0]        smag_q;
	logic [31:0]        amag_q, thrmag_q, ph_lo_q;
	logic signed [32:0] t0_q;
	logic [46:0]        a2mag_q, p1_q;
	logic               a2_pos_q, a2_neg_q, dbig_q, pbig_q;
	logic [15:0]        dhi_q;
	logic [16:0]        factor_q;
	logic signed [65:0] prod_q;

	// result register
	logic               res_valid_q;
	logic signed [23:0] speed_out_q;
	logic signed [31:0] thrust_out_q;
	logic [31:0]        power_out_q;

	// combinational
	logic signed [32:0] ma, mb;
	logic signed [24:0] span;
	logic signed [32:0] eff_term;
	logic signed [33:0] eff_sum;
	logic signed [23:0] cmd_next, s_next;
	logic signed [24:0] err, slew_raw, slew_clip, flo25, ceil25;
	logic [24:0]        err_mag, step25;
	logic signed [47:0] slip, a2;
	logic signed [48:0] a_diff;
	logic signed [31:0] a_sat, thr_d;
	logic [23:0]        smag_d;
	logic [31:0]        amag_d, thrmag_d, pw1, pw2, pw_res;
	logic [46:0]        a2mag_d;
	logic [32:0]        dsum, psum;
	logic               dcap, t0_pos, t0_neg;
	logic [16:0]        dfac, factor_d;
	logic signed [49:0] tp;

	assign stat.pc_neg   = pc_q[31];
	assign stat.out_free = !res_valid_q || res_ready;

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mul_sel)
			est_pkg::MUL_EFF: begin
				ma = 33'(cv_q);
				mb = 33'(span);
			end
			est_pkg::MUL_SLIP: begin
				ma = 33'(ks_q);
				mb = 33'(last_q);
			end
			est_pkg::MUL_LIN: begin
				ma = 33'(lin_q);
				mb = 33'(shaft_q);
			end
			est_pkg::MUL_SQ: begin
				ma = 33'(shaft_q);
				mb = $signed({9'd0, smag_q});
			end
			est_pkg::MUL_AA: begin
				ma = 33'(a_q);
				mb = $signed({1'b0, amag_q});
			end
			est_pkg::MUL_QUAD: begin
				ma = 33'(quad_q);
				mb = 33'(q_q);
			end
			est_pkg::MUL_KVH: begin
				ma = $signed({2'd0, a2mag_q[46:16]});
				mb = $signed({1'b0, kv_q});
			end
			est_pkg::MUL_KVL: begin
				ma = $signed({17'd0, a2mag_q[15:0]});
				mb = $signed({1'b0, kv_q});
			end
			est_pkg::MUL_THR: begin
				ma = t0_q;
				mb = $signed({16'd0, factor_q});
			end
			est_pkg::MUL_PW1: begin
				ma = pc_q[31] ? $signed({1'b0, thrmag_q}) : 33'(pc_q);
				mb = $signed({9'd0, smag_q});
			end
			est_pkg::MUL_PH: begin
				ma = $signed({2'd0, p1_q[46:16]});
				mb = $signed({1'b0, pcmag_q});
			end
			est_pkg::MUL_PL: begin
				ma = $signed({17'd0, p1_q[15:0]});
				mb = $signed({1'b0, pcmag_q});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// effort command: floor + floor(effort*span/2^16), saturated
	assign span     = 25'(ceil_q) - 25'(floor_q);
	assign eff_term = prod_q[48:16];
	assign eff_sum  = 34'(floor_q) + 34'(eff_term);

	always_comb begin
		cmd_next = cmd_q;
		case (func_q)
			est_pkg::FUNC_RPM:  cmd_next = cv_q;
			est_pkg::FUNC_EFFORT: begin
				if (eff_sum > 34'(SPD_MAX))
					cmd_next = SPD_MAX;
				else if (eff_sum < 34'(SPD_MIN))
					cmd_next = SPD_MIN;
				else
					cmd_next = eff_sum[23:0];
			end
			est_pkg::FUNC_KILL: cmd_next = '0;
			default:            cmd_next = cmd_q;
		endcase
	end

	// slew toward command, then floor clip, then ceiling clip
	always_comb begin
		flo25   = 25'(floor_q);
		ceil25  = 25'(ceil_q);
		step25  = {2'b00, step_q};
		err     = 25'(cmd_q) - 25'(shaft_q);
		err_mag = err[24] ? 25'(-err) : 25'(err);
		if (err_mag < step25)
			slew_raw = 25'(cmd_q);
		else if (!err[24])
			slew_raw = 25'(shaft_q) + $signed(step25);
		else
			slew_raw = 25'(shaft_q) - $signed(step25);
		slew_clip = slew_raw;
		if (slew_clip < flo25)
			slew_clip = flo25;
		if (slew_clip > ceil25)
			slew_clip = ceil25;
		s_next = slew_clip[23:0];
	end

	// airspeed seen by the rotor, with self slipstream
	assign slip   = prod_q[63:16];
	assign a_diff = 49'(axial_q) - 49'(slip);
	always_comb begin
		if (a_diff > 49'(W32_MAX))
			a_sat = W32_MAX;
		else if (a_diff < 49'(W32_MIN))
			a_sat = W32_MIN;
		else
			a_sat = a_diff[31:0];
	end

	assign smag_d  = shaft_q[23] ? 24'(-shaft_q) : 24'(shaft_q);
	assign amag_d  = a_q[31] ? 32'(-a_q) : 32'(a_q);
	assign a2      = prod_q[63:16];
	assign a2mag_d = a2[47] ? 47'(-a2) : 47'(a2);

	// decay factor
	assign dsum     = {17'd0, dhi_q} + {1'b0, prod_q[47:16]};
	assign dcap     = dbig_q || (dsum >= 33'd65536);
	assign dfac     = dcap ? 17'd0 : 17'(33'd65536 - dsum);
	assign t0_pos   = !t0_q[32] && (t0_q != '0);
	assign t0_neg   = t0_q[32];
	assign factor_d = ((a2_pos_q && t0_pos) || (a2_neg_q && t0_neg)) ? dfac : UNITY;

	// decayed thrust
	assign tp = prod_q[65:16];
	always_comb begin
		if (tp > 50'(W32_MAX))
			thr_d = W32_MAX;
		else if (tp < 50'(W32_MIN))
			thr_d = W32_MIN;
		else
			thr_d = tp[31:0];
	end
	assign thrmag_d = thr_d[31] ? 32'(-thr_d) : 32'(thr_d);

	// power
	assign pw1    = (|prod_q[65:40]) ? '1 : prod_q[39:8];
	assign psum   = {1'b0, ph_lo_q} + {1'b0, prod_q[47:16]};
	assign pw2    = (pbig_q || psum[32]) ? '1 : psum[31:0];
	assign pw_res = (cmd.wb_sel == est_pkg::WB_PWR2) ? pw2 : pw1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q   <= '0;
			quad_q  <= '0;
			kv_q    <= '0;
			ks_q    <= '0;
			floor_q <= '0;
			ceil_q  <= est_pkg::SPD_CEIL_RST;
			step_q  <= est_pkg::MAX_STEP_RST;
			pc_q    <= '0;
			pcmag_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				est_pkg::REG_LIN_COEF:   lin_q   <= cfg_data;
				est_pkg::REG_QUAD_COEF:  quad_q  <= cfg_data;
				est_pkg::REG_AIR_DECAY:  kv_q    <= cfg_data;
				est_pkg::REG_SLIP_GAIN:  ks_q    <= cfg_data;
				est_pkg::REG_SPD_FLOOR:  floor_q <= cfg_data[23:0];
				est_pkg::REG_SPD_CEIL:   ceil_q  <= cfg_data[23:0];
				est_pkg::REG_MAX_STEP:   step_q  <= cfg_data[22:0];
				est_pkg::REG_POWER_COEF: begin
					pc_q    <= cfg_data;
					pcmag_q <= cfg_data[31] ? 32'(-cfg_data) : cfg_data;
				end
				default: ;
			endcase
		end
	end

	// tick state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shaft_q     <= '0;
			cmd_q       <= '0;
			last_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (cmd.wb_sel)
				est_pkg::WB_CMD:  cmd_q   <= cmd_next;
				est_pkg::WB_SLEW: shaft_q <= s_next;
				est_pkg::WB_THR:  last_q  <= thr_d;
				default: ;
			endcase
			if (cmd.out_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// item latch, product and intermediates
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			cv_q    <= command_value;
			axial_q <= axial_airspeed;
		end
		if (cmd.mul_sel != est_pkg::MUL_NONE)
			prod_q <= ma * mb;
		case (cmd.wb_sel)
			est_pkg::WB_SLEW: a_q <= a_sat;
			est_pkg::WB_MAG: begin
				smag_q <= smag_d;
				amag_q <= amag_d;
			end
			est_pkg::WB_LIN:  t0_q <= 33'($signed(prod_q[55:24]));
			est_pkg::WB_SQ:   q_q  <= prod_q[47:16];
			est_pkg::WB_AA: begin
				a2mag_q  <= a2mag_d;
				a2_pos_q <= !a2[47] && (a2 != '0);
				a2_neg_q <= a2[47];
			end
			est_pkg::WB_QUAD: t0_q <= t0_q + 33'($signed(prod_q[63:32]));
			est_pkg::WB_KVH: begin
				dbig_q <= |prod_q[65:16];
				dhi_q  <= prod_q[15:0];
			end
			est_pkg::WB_FACT: factor_q <= factor_d;
			est_pkg::WB_THR:  thrmag_q <= thrmag_d;
			est_pkg::WB_PWR1: p1_q     <= prod_q[54:8];
			est_pkg::WB_PH: begin
				pbig_q  <= |prod_q[65:32];
				ph_lo_q <= prod_q[31:0];
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			speed_out_q  <= shaft_q;
			thrust_out_q <= last_q;
			power_out_q  <= pw_res;
		end
	end

	assign res_valid  = res_valid_q;
	assign speed_out  = speed_out_q;
	assign thrust_out = thrust_out_q;
	assign power_out  = power_out_q;

endmodule

// ===== src/est_ctrl.sv =====
// Controller: sequences one item through the shared multiplier and writebacks.
// Depends on est_pkg; drives est_dp through dp_cmd_t and reads dp_stat_t.
module est_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  est_pkg::dp_stat_t  stat,
	output est_pkg::dp_cmd_t   cmd
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_EFF  = 5'd1;
	localparam logic [4:0] ST_CMD  = 5'd2;
	localparam logic [4:0] ST_SLEW = 5'd3;
	localparam logic [4:0] ST_LIN  = 5'd4;
	localparam logic [4:0] ST_SQ   = 5'd5;
	localparam logic [4:0] ST_AA   = 5'd6;
	localparam logic [4:0] ST_QUAD = 5'd7;
	localparam logic [4:0] ST_KVH  = 5'd8;
	localparam logic [4:0] ST_KVL  = 5'd9;
	localparam logic [4:0] ST_FACT = 5'd10;
	localparam logic [4:0] ST_THR  = 5'd11;
	localparam logic [4:0] ST_TWB  = 5'd12;
	localparam logic [4:0] ST_PW1  = 5'd13;
	localparam logic [4:0] ST_PWR1 = 5'd14;
	localparam logic [4:0] ST_PH   = 5'd15;
	localparam logic [4:0] ST_PL   = 5'd16;
	localparam logic [4:0] ST_PWR2 = 5'd17;

	logic [4:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.mul_sel  = est_pkg::MUL_NONE;
		cmd.wb_sel   = est_pkg::WB_NONE;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EFF;
				end
			end
			ST_EFF: begin
				cmd.mul_sel = est_pkg::MUL_EFF;
				state_d     = ST_CMD;
			end
			ST_CMD: begin
				cmd.mul_sel = est_pkg::MUL_SLIP;
				cmd.wb_sel  = est_pkg::WB_CMD;
				state_d     = ST_SLEW;
			end
			ST_SLEW: begin
				cmd.wb_sel = est_pkg::WB_SLEW;
				state_d    = ST_LIN;
			end
			ST_LIN: begin
				cmd.mul_sel = est_pkg::MUL_LIN;
				cmd.wb_sel  = est_pkg::WB_MAG;
				state_d     = ST_SQ;
			end
			ST_SQ: begin
				cmd.mul_sel = est_pkg::MUL_SQ;
				cmd.wb_sel  = est_pkg::WB_LIN;
				state_d     = ST_AA;
			end
			ST_AA: begin
				cmd.mul_sel = est_pkg::MUL_AA;
				cmd.wb_sel  = est_pkg::WB_SQ;
				state_d     = ST_QUAD;
			end
			ST_QUAD: begin
				cmd.mul_sel = est_pkg::MUL_QUAD;
				cmd.wb_sel  = est_pkg::WB_AA;
				state_d     = ST_KVH;
			end
			ST_KVH: begin
				cmd.mul_sel = est_pkg::MUL_KVH;
				cmd.wb_sel  = est_pkg::WB_QUAD;
				state_d     = ST_KVL;
			end
			ST_KVL: begin
				cmd.mul_sel = est_pkg::MUL_KVL;
				cmd.wb_sel  = est_pkg::WB_KVH;
				state_d     = ST_FACT;
			end
			ST_FACT: begin
				cmd.wb_sel = est_pkg::WB_FACT;
				state_d    = ST_THR;
			end
			ST_THR: begin
				cmd.mul_sel = est_pkg::MUL_THR;
				state_d     = ST_TWB;
			end
			ST_TWB: begin
				cmd.wb_sel = est_pkg::WB_THR;
				state_d    = ST_PW1;
			end
			ST_PW1: begin
				cmd.mul_sel = est_pkg::MUL_PW1;
				state_d     = ST_PWR1;
			end
			ST_PWR1: begin
				// nonnegative coef finishes here; negative goes on to the long product
				cmd.wb_sel = est_pkg::WB_PWR1;
				if (stat.pc_neg)
					state_d = ST_PH;
				else if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_PH: begin
				cmd.mul_sel = est_pkg::MUL_PH;
				state_d     = ST_PL;
			end
			ST_PL: begin
				cmd.mul_sel = est_pkg::MUL_PL;
				cmd.wb_sel  = est_pkg::WB_PH;
				state_d     = ST_PWR2;
			end
			ST_PWR2: begin
				cmd.wb_sel = est_pkg::WB_PWR2;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== src/esc_slew_thruster_step.sv =====
// Top level of the slewed thruster tick block: controller plus datapath.
// Depends on est_pkg, est_if (channels), est_ctrl and est_dp.
//
// One item is one simulation tick: it may latch a new shaft speed command
// (rpm, effort between speed_floor and speed_ceiling, or kill), slews the
// shaft toward it by at most max_step, clips it, and returns one result
// with shaft speed, decayed thrust and power. All math is fixed point with
// floor rounding and runs through a single shared 33x33 signed multiplier,
// one product per cycle, so that multiplier sets the rate; a negative
// power_coef adds one extra 47x32 product, split in two, before the
// result is valid. A new item is taken in the cycle after the previous
// result is loaded into the output register, which holds it until the
// sink takes it; the last step waits only if that register is still full.
// Config writes are taken every cycle and must only be issued while no
// item is in flight.

module esc_slew_thruster_step (
	input  logic          clk,
	input  logic          arst_n,
	est_tick_if.sink      tick,
	est_result_if.source  result,
	est_cfg_if.sink       cfg
);

	est_pkg::dp_cmd_t  cmd;
	est_pkg::dp_stat_t stat;

	// config is plain register writes; always ready
	assign cfg.ready = 1'b1;

	// sequencer: one step per cycle unless the result register is still full, ready only between items
	est_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers, multiplier and the result register
	est_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.func           (tick.func),
		.command_value  (tick.command_value),
		.axial_airspeed (tick.axial_airspeed),
		.res_valid      (result.valid),
		.res_ready      (result.ready),
		.speed_out      (result.speed_out),
		.thrust_out     (result.thrust_out),
		.power_out      (result.power_out)
	);

endmodule
